@@ hw/rtl/huffman_symbol_encoder_top_macros.svh @@
// assertion macros for the huffman symbol encoder checker
// expects clk_i and rst_ni in the scope of use
`ifndef HUFFMAN_SYMBOL_ENCODER_TOP_MACROS_SVH
`define HUFFMAN_SYMBOL_ENCODER_TOP_MACROS_SVH

// clocked property, off while reset is asserted
`define HSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// a stalled output item keeps the given signal
`define HSE_ASSERT_HOLD(lbl, sig, msg) \
  `HSE_ASSERT(lbl, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(sig), msg)

`endif

@@ hw/rtl/hse_pkg.sv @@
// shared types and constants of the huffman symbol encoder
// no dependencies
package hse_pkg;

  localparam int MaxCodeLen  = 32;
  localparam int SymbolCount = 256;

  localparam int SymW      = 8;
  localparam int ValW      = 32;
  localparam int LenW      = 6;
  localparam int StatW     = 2;
  localparam int KindW     = 2;
  localparam int LenCap    = (MaxCodeLen < ValW) ? MaxCodeLen : ValW;
  localparam int LenStoreW = $clog2(LenCap + 1);
  localparam int PendW     = SymW - 1;
  localparam int PendCntW  = $clog2(SymW);
  localparam int AccW      = LenCap + PendW;
  localparam int CntW      = $clog2(AccW + 1);
  localparam int SymAddrW  = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;
  localparam int InDataW   = ((SymW + ValW + LenW + 7) / 8) * 8;
  localparam int OutDataW  = SymW;

  typedef enum logic [KindW-1:0] {
    KindLoad   = 2'd0,
    KindEncode = 2'd1,
    KindFlush  = 2'd2
  } kind_e;

  typedef enum logic [StatW-1:0] {
    StatData  = 2'd0,
    StatError = 2'd1,
    StatEnd   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StMerge,
    StEmit,
    StSingle
  } state_e;

  typedef struct packed {
    logic [LenCap-1:0]    bits;
    logic [LenStoreW-1:0] len;
  } code_entry_t;

  typedef struct packed {
    logic            shift_left;
    logic [CntW-1:0] amount;
  } shift_req_t;

endpackage

@@ hw/rtl/hse_code_mem.sv @@
// code table memory: one code entry per symbol, registered read
// depends on hse_pkg
module hse_code_mem (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [hse_pkg::SymAddrW-1:0] wr_addr_i,
  input  hse_pkg::code_entry_t       wr_data_i,
  input  logic                       rd_en_i,
  input  logic [hse_pkg::SymAddrW-1:0] rd_addr_i,
  output hse_pkg::code_entry_t       rd_data_o
);
  import hse_pkg::*;

  code_entry_t mem_q [SymbolCount];
  code_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/hse_shift_unit.sv @@
// shared barrel shifter used for code merge, byte extraction and flush alignment
// depends on hse_pkg
module hse_shift_unit (
  input  logic [hse_pkg::AccW-1:0] operand_i,
  input  hse_pkg::shift_req_t      req_i,
  output logic [hse_pkg::AccW-1:0] result_o
);
  import hse_pkg::*;

  always_comb begin
    if (req_i.shift_left) begin
      result_o = operand_i << req_i.amount;
    end else begin
      result_o = operand_i >> req_i.amount;
    end
  end

endmodule

@@ hw/rtl/huffman_symbol_encoder_top.sv @@
// huffman symbol encoder: code table, bit packer and sequencer
// depends on hse_pkg, hse_code_mem, hse_shift_unit
//
// Input channel (s_axis): tuser carries the kind of item. A load item writes the
// code of one symbol into the table (length zero removes it), an encode item
// appends the symbol's code to the pending bits, a flush item ends the stream.
// Output channel (m_axis): one packed byte per item, status in tuser, tlast on the
// final item of a stream (flush result or missing-code error).
// A load item, and an encode item while an error is latched, are done in StIdle.
// A flush or a missing-code encode passes through StSingle, which registers its
// result into the output register. An encode that yields n bytes (0 to 4) first
// reads the table, then merges in the shared shifter (StMerge), then in StEmit
// gives one byte per cycle from that same shifter while the receiver does not
// stall, and at last stores the leftover bits as pending bits.
// s_axis_tready is high only between items.
// Reset clears the table valid bits, pending bits and the error latch; the table
// memory itself is not cleared. When the receiver stalls, the output register
// holds its item and the sequencer waits with the next byte.
module huffman_symbol_encoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // symbol [7:0], code_value [39:8], code_length [45:40], zero fill [47:46]
  input  logic [hse_pkg::InDataW-1:0] s_axis_tdata,
  // kind [1:0]
  input  logic [hse_pkg::KindW-1:0]   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_byte [7:0]
  output logic [hse_pkg::OutDataW-1:0] m_axis_tdata,
  // status [1:0]
  output logic [hse_pkg::StatW-1:0]   m_axis_tuser,
  output logic                        m_axis_tlast
);
  import hse_pkg::*;

  state_e                state_q, state_d;
  logic [AccW-1:0]       acc_q, acc_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PendW-1:0]      pend_bits_q, pend_bits_d;
  logic [PendCntW-1:0]   pend_cnt_q, pend_cnt_d;
  logic                  err_q, err_d;
  logic [SymW-1:0]       res_byte_q, res_byte_d;
  status_e               res_stat_q, res_stat_d;
  logic                  m_valid_q, m_valid_d;
  logic [SymW-1:0]       m_byte_q, m_byte_d;
  status_e               m_stat_q, m_stat_d;
  logic                  m_last_q, m_last_d;
  logic [SymbolCount-1:0] valid_q;

  kind_e                 in_kind;
  logic [SymW-1:0]       in_symbol;
  logic [ValW-1:0]       in_value;
  logic [LenW-1:0]       in_len;
  logic [LenW-1:0]       len_cap;
  logic [ValW-1:0]       val_mask;
  logic                  in_accept;
  logic                  sym_in_range;
  logic [SymAddrW-1:0]   sym_addr;
  logic                  valid_hit;
  logic                  load_take;
  logic                  out_free;
  code_entry_t           wr_entry;
  code_entry_t           rd_entry;
  shift_req_t            sh_req;
  logic [AccW-1:0]       sh_operand;
  logic [AccW-1:0]       sh_result;
  logic [PendW-1:0]      pend_mask;

  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_symbol = s_axis_tdata[SymW-1:0];
  assign in_value  = s_axis_tdata[SymW +: ValW];
  assign in_len    = s_axis_tdata[SymW + ValW +: LenW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign sym_in_range  = ({1'b0, in_symbol} < (SymW + 1)'(SymbolCount));
  assign sym_addr      = in_symbol[SymAddrW-1:0];
  assign valid_hit     = sym_in_range && valid_q[sym_addr];
  assign load_take     = in_accept && (in_kind == KindLoad) && sym_in_range;

  // saturate the length and keep only the low code bits
  assign len_cap       = (in_len > LenW'(LenCap)) ? LenW'(LenCap) : in_len;
  assign val_mask      = ~({ValW{1'b1}} << len_cap);
  assign wr_entry.bits = LenCap'(in_value & val_mask);
  assign wr_entry.len  = LenStoreW'(len_cap);

  hse_code_mem u_code_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_take && (in_len != '0)),
    .wr_addr_i (sym_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (in_accept),
    .rd_addr_i (sym_addr),
    .rd_data_o (rd_entry)
  );

  // shifter use: merge in StMerge, byte pick in StEmit, flush alignment otherwise
  always_comb begin
    case (state_q)
      StMerge: begin
        sh_req.shift_left = 1'b1;
        sh_req.amount     = CntW'(rd_entry.len);
        sh_operand        = AccW'(pend_bits_q);
      end
      StEmit: begin
        sh_req.shift_left = 1'b0;
        sh_req.amount     = cnt_q - CntW'(SymW);
        sh_operand        = acc_q;
      end
      default: begin
        sh_req.shift_left = 1'b1;
        sh_req.amount     = CntW'(SymW) - CntW'(pend_cnt_q);
        sh_operand        = AccW'(pend_bits_q);
      end
    endcase
  end

  hse_shift_unit u_shift_unit (
    .operand_i (sh_operand),
    .req_i     (sh_req),
    .result_o  (sh_result)
  );

  assign out_free  = !m_valid_q || m_axis_tready;
  assign pend_mask = ~({PendW{1'b1}} << cnt_q[PendCntW-1:0]);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    err_d       = err_q;
    res_byte_d  = res_byte_q;
    res_stat_d  = res_stat_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_byte_d    = m_byte_q;
    m_stat_d    = m_stat_q;
    m_last_d    = m_last_q;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          case (in_kind)
            KindEncode: begin
              if (!err_q) begin
                if (valid_hit) begin
                  state_d = StMerge;
                end else begin
                  res_byte_d  = '0;
                  res_stat_d  = StatError;
                  pend_bits_d = '0;
                  pend_cnt_d  = '0;
                  err_d       = 1'b1;
                  state_d     = StSingle;
                end
              end
            end
            KindFlush: begin
              if (pend_cnt_q != '0) begin
                res_byte_d = sh_result[SymW-1:0];
                res_stat_d = StatData;
              end else begin
                res_byte_d = '0;
                res_stat_d = StatEnd;
              end
              pend_bits_d = '0;
              pend_cnt_d  = '0;
              err_d       = 1'b0;
              state_d     = StSingle;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StMerge: begin
        acc_d   = sh_result | AccW'(rd_entry.bits);
        cnt_d   = CntW'(pend_cnt_q) + CntW'(rd_entry.len);
        state_d = StEmit;
      end
      StEmit: begin
        if (cnt_q >= CntW'(SymW)) begin
          if (out_free) begin
            m_valid_d = 1'b1;
            m_byte_d  = sh_result[SymW-1:0];
            m_stat_d  = StatData;
            m_last_d  = 1'b0;
            cnt_d     = cnt_q - CntW'(SymW);
          end
        end else begin
          pend_cnt_d  = cnt_q[PendCntW-1:0];
          pend_bits_d = acc_q[PendW-1:0] & pend_mask;
          state_d     = StIdle;
        end
      end
      StSingle: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_byte_d  = res_byte_q;
          m_stat_d  = res_stat_q;
          m_last_d  = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      err_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      err_q       <= err_d;
      m_valid_q   <= m_valid_d;
      if (load_take) begin
        valid_q[sym_addr] <= (in_len != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    res_byte_q <= res_byte_d;
    res_stat_q <= res_stat_d;
    m_byte_q   <= m_byte_d;
    m_stat_q   <= m_stat_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_byte_q;
  assign m_axis_tuser  = m_stat_q;
  assign m_axis_tlast  = m_last_q;

endmodule

@@ hw/rtl/hse_checker.sv @@
// port-level checker for the huffman symbol encoder, bound to the top level
// depends on hse_pkg and huffman_symbol_encoder_top_macros.svh
`include "huffman_symbol_encoder_top_macros.svh"

module hse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [hse_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [hse_pkg::KindW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hse_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [hse_pkg::StatW-1:0]     m_axis_tuser,
  input logic                          m_axis_tlast
);
  import hse_pkg::*;

  logic flush_take;
  logic load_take;
  logic in_seen;

  assign flush_take = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KindFlush);
  assign load_take  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == KindLoad);
  assign in_seen    = (s_axis_tdata != '0) || 1'b1;

  `HSE_ASSERT_HOLD(a_out_hold, m_axis_tdata, "stalled output item changed")
  `HSE_ASSERT(a_flush_busy, flush_take |=> !s_axis_tready, "ready after flush item")
  `HSE_ASSERT(a_load_ready, load_take && in_seen |=> s_axis_tready, "busy after load item")
  `HSE_ASSERT(a_end_last, m_axis_tvalid && m_axis_tuser != StatData |-> m_axis_tlast, "no tlast")

endmodule

bind huffman_symbol_encoder_top hse_checker u_hse_checker (.*);
